@@ design/bpa_pkg.sv @@
`default_nettype none
package bpa_pkg;
  localparam int NUM_PAGES = 65536;
  localparam int WORD_BITS = 64;
  localparam int MAP_DEPTH = NUM_PAGES / WORD_BITS;
  localparam int ADDR_W = $clog2(MAP_DEPTH);
  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int CNT_W = 17;
  localparam int PAGE_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] PAGE_LIMIT = CNT_W'(NUM_PAGES);
  localparam logic [CNT_W-1:0] RST_TOTAL = 17'd65536;
  localparam logic [PAGE_W-1:0] RST_SEARCH = 16'd256;
  localparam logic [CNT_W-1:0] RST_RESERVED = 17'd65536;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE = 2'd1;
  localparam logic [1:0] MODE_RESERVE = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  localparam logic [1:0] STS_DONE = 2'd0;
  localparam logic [1:0] STS_NORUN = 2'd1;
  localparam logic [1:0] STS_ZERO = 2'd2;

  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_SEARCH = 1'b1;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
  } ram_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] alloc_page;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  reserved_pages;
  } result_t;
endpackage
`default_nettype wire

@@ design/bpa_in_if.sv @@
`default_nettype none
interface bpa_in_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [PAGE_W-1:0] first_page;
  logic [CNT_W-1:0]  page_count;
  modport source (output valid, mode, first_page, page_count, input ready);
  modport sink (input valid, mode, first_page, page_count, output ready);
endinterface
`default_nettype wire

@@ design/bpa_out_if.sv @@
`default_nettype none
interface bpa_out_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PAGE_W-1:0] alloc_page;
  logic [CNT_W-1:0]  free_pages;
  logic [CNT_W-1:0]  used_pages;
  logic [CNT_W-1:0]  reserved_pages;
  modport source (output valid, status, alloc_page, free_pages, used_pages, reserved_pages,
                  input ready);
  modport sink (input valid, status, alloc_page, free_pages, used_pages, reserved_pages,
                output ready);
endinterface
`default_nettype wire

@@ design/bpa_cfg_if.sv @@
`default_nettype none
interface bpa_cfg_if;
  import bpa_pkg::*;
  logic             valid;
  logic             ready;
  logic             index;
  logic [CNT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/bpa_map_ram.sv @@
`default_nettype none
module bpa_map_ram
  import bpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire ram_req_t             req,
  output logic [WORD_BITS-1:0]      rdata_r
);
  logic [WORD_BITS-1:0] mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end
endmodule
`default_nettype wire

@@ design/bpa_engine.sv @@
`default_nettype none
module bpa_engine
  import bpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [1:0]           mode,
  input  wire logic [PAGE_W-1:0]    first_page,
  input  wire logic [CNT_W-1:0]     page_count,
  input  wire logic [CNT_W-1:0]     limit,
  input  wire logic [PAGE_W-1:0]    search_start,
  input  wire logic [WORD_BITS-1:0] rdata,
  output ram_req_t                  req,
  output logic                      idle,
  output logic                      fin_r,
  output result_t                   res
);
  localparam logic [1:0] S_CLR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD = 2'd2;
  localparam logic [1:0] S_WORK = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0] p_r, p_nxt, rem_r, rem_nxt, run_r, run_nxt, cnt_r, cnt_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  logic [1:0] op_r, op_nxt, status_r, status_nxt;
  logic scan_r, scan_nxt, fresh_r, fresh_nxt, fin_nxt;
  logic [PAGE_W-1:0] alloc_r, alloc_nxt;
  logic [WORD_BITS-1:0] wbuf_r, wbuf_nxt, cur, nb;
  logic [CNT_W-1:0] free_r, free_nxt, used_r, used_nxt, rsv_r, rsv_nxt;
  logic [CNT_W-1:0] p_inc, start_sel;
  logic bit_v, stop;

  function automatic logic [CNT_W-1:0] inc1(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction
  function automatic logic [CNT_W-1:0] dec1(input logic [CNT_W-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

  assign idle = (state_r == S_IDLE) && !fin_r;
  assign res = '{status: status_r, alloc_page: alloc_r, free_pages: free_r,
                 used_pages: used_r, reserved_pages: rsv_r};

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    p_nxt = p_r;
    rem_nxt = rem_r;
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    start_nxt = start_r;
    op_nxt = op_r;
    status_nxt = status_r;
    scan_nxt = scan_r;
    fresh_nxt = 1'b0;
    fin_nxt = 1'b0;
    alloc_nxt = alloc_r;
    free_nxt = free_r;
    used_nxt = used_r;
    rsv_nxt = rsv_r;
    req = '0;
    cur = fresh_r ? rdata : wbuf_r;
    bit_v = cur[p_r[BIT_W-1:0]];
    nb = cur;
    wbuf_nxt = wbuf_r;
    p_inc = p_r + 1'b1;
    start_sel = (run_r == '0) ? p_r : start_r;
    stop = 1'b0;
    unique case (state_r)
      S_CLR: begin
        req.we = 1'b1;
        req.waddr = clr_r;
        req.wdata = '1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt = mode;
          cnt_nxt = page_count;
          rem_nxt = page_count;
          run_nxt = '0;
          status_nxt = STS_DONE;
          alloc_nxt = '0;
          if (page_count == '0) begin
            status_nxt = STS_ZERO;
            fin_nxt = 1'b1;
          end else if (mode == MODE_ALLOC) begin
            p_nxt = {1'b0, search_start};
            scan_nxt = 1'b1;
            if ({1'b0, search_start} >= limit) begin
              status_nxt = STS_NORUN;
              fin_nxt = 1'b1;
            end else begin
              state_nxt = S_RD;
            end
          end else begin
            p_nxt = {1'b0, first_page};
            scan_nxt = 1'b0;
            if ((mode == MODE_FREE && first_page == '0) || {1'b0, first_page} >= limit) begin
              fin_nxt = 1'b1;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        req.re = 1'b1;
        req.raddr = p_r[BIT_W +: ADDR_W];
        fresh_nxt = 1'b1;
        state_nxt = S_WORK;
      end
      S_WORK: begin
        wbuf_nxt = cur;
        p_nxt = p_inc;
        if (scan_r) begin
          if (!bit_v) begin
            start_nxt = start_sel;
            run_nxt = run_r + 1'b1;
            if (run_r + 1'b1 == cnt_r) begin
              scan_nxt = 1'b0;
              p_nxt = start_sel;
              rem_nxt = cnt_r;
              state_nxt = S_RD;
            end
          end else begin
            run_nxt = '0;
          end
          if (state_nxt == S_WORK) begin
            if (p_inc >= limit) begin
              status_nxt = STS_NORUN;
              fin_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else if (&p_r[BIT_W-1:0]) begin
              state_nxt = S_RD;
            end
          end
        end else begin
          case (op_r)
            MODE_ALLOC: begin
              nb[p_r[BIT_W-1:0]] = 1'b1;
              free_nxt = dec1(free_r);
              used_nxt = inc1(used_r);
            end
            MODE_FREE: begin
              if (bit_v) begin
                nb[p_r[BIT_W-1:0]] = 1'b0;
                free_nxt = inc1(free_r);
                used_nxt = dec1(used_r);
              end
            end
            MODE_RESERVE: begin
              if (!bit_v) begin
                nb[p_r[BIT_W-1:0]] = 1'b1;
                free_nxt = dec1(free_r);
                rsv_nxt = inc1(rsv_r);
              end
            end
            default: begin
              if (bit_v) begin
                nb[p_r[BIT_W-1:0]] = 1'b0;
                free_nxt = inc1(free_r);
                rsv_nxt = dec1(rsv_r);
              end
            end
          endcase
          wbuf_nxt = nb;
          rem_nxt = rem_r - 1'b1;
          stop = (rem_r == 17'd1) || (p_inc >= limit);
          if (stop || (&p_r[BIT_W-1:0])) begin
            req.we = 1'b1;
            req.waddr = p_r[BIT_W +: ADDR_W];
            req.wdata = nb;
          end
          if (stop) begin
            fin_nxt = 1'b1;
            state_nxt = S_IDLE;
            if (op_r == MODE_ALLOC) begin
              alloc_nxt = start_r[PAGE_W-1:0];
            end
          end else if (&p_r[BIT_W-1:0]) begin
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      fin_r <= 1'b0;
      fresh_r <= 1'b0;
      free_r <= '0;
      used_r <= '0;
      rsv_r <= RST_RESERVED;
      scan_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      fin_r <= fin_nxt;
      fresh_r <= fresh_nxt;
      free_r <= free_nxt;
      used_r <= used_nxt;
      rsv_r <= rsv_nxt;
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    rem_r <= rem_nxt;
    run_r <= run_nxt;
    cnt_r <= cnt_nxt;
    start_r <= start_nxt;
    op_r <= op_nxt;
    status_r <= status_nxt;
    alloc_r <= alloc_nxt;
    wbuf_r <= wbuf_nxt;
  end
endmodule
`default_nettype wire

@@ design/bitmap_page_allocator.sv @@
// Bitmap page allocator: one busy bit per page in a 1024 x 64 map memory plus free, used
// and reserved counters. After reset a clearing pass marks every page reserved; no item
// is taken during that pass. Items are handled one at a time and each returns one result.
// An item that touches the map walks it one page per cycle, pausing for a memory read at
// each map word it touches; allocate scans from search_start_page until a fitting run is
// found or the page limit is reached, and then walks the run to mark it. Configuration
// writes are taken at once.
`default_nettype none
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpa_in_if.sink     in_if,
  bpa_out_if.source  out_if,
  bpa_cfg_if.sink    cfg_if
);
  logic [CNT_W-1:0] total_r;
  logic [PAGE_W-1:0] search_r;
  logic [CNT_W-1:0] limit;
  logic out_valid_r, eng_idle, fin, start;
  result_t res, out_r;
  ram_req_t req;
  logic [WORD_BITS-1:0] rdata;

  assign limit = (total_r > PAGE_LIMIT) ? PAGE_LIMIT : total_r;
  assign cfg_if.ready = 1'b1;
  assign in_if.ready = eng_idle && !out_valid_r;
  assign start = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= RST_TOTAL;
      search_r <= RST_SEARCH;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          REG_TOTAL: total_r <= cfg_if.data;
          REG_SEARCH: search_r <= cfg_if.data[PAGE_W-1:0];
          default: ;
        endcase
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_r <= res;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.status = out_r.status;
  assign out_if.alloc_page = out_r.alloc_page;
  assign out_if.free_pages = out_r.free_pages;
  assign out_if.used_pages = out_r.used_pages;
  assign out_if.reserved_pages = out_r.reserved_pages;

  bpa_map_ram u_ram (
    .clk,
    .req,
    .rdata_r(rdata)
  );

  bpa_engine u_eng (
    .clk,
    .rst_n,
    .start,
    .mode(in_if.mode),
    .first_page(in_if.first_page),
    .page_count(in_if.page_count),
    .limit,
    .search_start(search_r),
    .rdata,
    .req,
    .idle(eng_idle),
    .fin_r(fin),
    .res
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !eng_idle |-> !in_if.ready) else $error("input taken while engine busy");
  a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !out_valid_r) else $error("result overwrites pending result");
  a_norun_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status != STS_DONE |-> out_if.alloc_page == '0)
    else $error("page reported without allocation");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.status != 2'd3) else $error("bad status");
endmodule
`default_nettype wire

@@ test/bitmap_page_allocator_tb.sv @@
`timescale 1ns / 1ps
module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  class page_map_scoreboard;
    bit               busy[NUM_PAGES];
    int               free_cnt;
    int               used_cnt;
    int               rsvd_cnt;
    int               total_reg;
    int               search_reg;
    result_t          pending[$];
    int               alloc_starts[$];
    int               errors;

    function new();
      foreach (busy[i]) busy[i] = 1'b1;
      free_cnt = 0;
      used_cnt = 0;
      rsvd_cnt = 65536;
      total_reg = RST_TOTAL;
      search_reg = RST_SEARCH;
      errors = 0;
    endfunction

    function int inc_sat(int c, int n);
      return (c + n > CNT_MAX) ? CNT_MAX : c + n;
    endfunction

    function int dec_sat(int c, int n);
      return (c > n) ? c - n : 0;
    endfunction

    function void write_reg(logic idx, logic [CNT_W-1:0] value);
      if (idx == REG_TOTAL) total_reg = value;
      else search_reg = value[PAGE_W-1:0];
    endfunction

    function void note_item(logic [1:0] mode, logic [PAGE_W-1:0] first,
                            logic [CNT_W-1:0] count);
      result_t r;
      int limit, run, start, p;
      bit found;
      limit = (total_reg > NUM_PAGES) ? NUM_PAGES : total_reg;
      r = '0;
      if (count == 0) begin
        r.status = STS_ZERO;
      end else if (mode == MODE_ALLOC) begin
        run = 0;
        start = 0;
        found = 0;
        for (p = search_reg; p < limit; p++) begin
          if (!busy[p]) begin
            if (run == 0) start = p;
            run++;
            if (run == count) begin
              found = 1;
              break;
            end
          end else begin
            run = 0;
          end
        end
        if (found) begin
          for (p = start; p < start + count; p++) busy[p] = 1'b1;
          free_cnt = dec_sat(free_cnt, count);
          used_cnt = inc_sat(used_cnt, count);
          r.alloc_page = PAGE_W'(start);
          alloc_starts.push_back(start);
        end else begin
          r.status = STS_NORUN;
        end
      end else if (!(mode == MODE_FREE && first == 0)) begin
        for (p = first; p < first + count && p < limit; p++) begin
          if (mode == MODE_RESERVE) begin
            if (!busy[p]) begin
              busy[p] = 1'b1;
              free_cnt = dec_sat(free_cnt, 1);
              rsvd_cnt = inc_sat(rsvd_cnt, 1);
            end
          end else if (busy[p]) begin
            busy[p] = 1'b0;
            free_cnt = inc_sat(free_cnt, 1);
            if (mode == MODE_FREE) used_cnt = dec_sat(used_cnt, 1);
            else rsvd_cnt = dec_sat(rsvd_cnt, 1);
          end
        end
      end
      r.free_pages = CNT_W'(free_cnt);
      r.used_pages = CNT_W'(used_cnt);
      r.reserved_pages = CNT_W'(rsvd_cnt);
      pending.push_back(r);
    endfunction

    function void field_check(string name, int e, int a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch expected %0d actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %p", $time, got);
        return;
      end
      e = pending.pop_front();
      field_check("status", e.status, got.status);
      field_check("alloc_page", e.alloc_page, got.alloc_page);
      field_check("free_pages", e.free_pages, got.free_pages);
      field_check("used_pages", e.used_pages, got.used_pages);
      field_check("reserved_pages", e.reserved_pages, got.reserved_pages);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   hold_left = 0;
  bit   idle_on = 1'b1;
  page_map_scoreboard sb;

  bpa_in_if  in_if();
  bpa_out_if out_if();
  bpa_cfg_if cfg_if();

  bitmap_page_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_page_allocator test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= idle_on ? ($urandom_range(99) >= 7) : 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.status = out_if.status;
      got.alloc_page = out_if.alloc_page;
      got.free_pages = out_if.free_pages;
      got.used_pages = out_if.used_pages;
      got.reserved_pages = out_if.reserved_pages;
      sb.check_result(got);
    end
  end

  task automatic send_item(logic [1:0] mode, logic [PAGE_W-1:0] first,
                           logic [CNT_W-1:0] count);
    while (idle_on && $urandom_range(99) < 7) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= mode;
    in_if.first_page <= first;
    in_if.page_count <= count;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(mode, first, count);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [CNT_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_item(int total);
    logic [1:0] mode;
    logic [PAGE_W-1:0] first;
    logic [CNT_W-1:0] count;
    int r;
    r = $urandom_range(99);
    mode = (r < 35) ? MODE_ALLOC : (r < 65) ? MODE_FREE : (r < 80) ? MODE_RESERVE
         : MODE_RELEASE;
    r = $urandom_range(99);
    count = (r < 5) ? 17'd0 : (r < 8) ? 17'd65536
          : (r < 11) ? CNT_W'($urandom_range(0, 65536))
          : CNT_W'($urandom_range(1, 24));
    r = $urandom_range(99);
    if (r < 8) first = PAGE_W'($urandom_range(0, 65535));
    else if (mode == MODE_FREE && r < 60 && sb.alloc_starts.size() != 0)
      first = PAGE_W'(sb.alloc_starts[$urandom_range(0, sb.alloc_starts.size() - 1)]);
    else first = PAGE_W'($urandom_range(0, total + 8));
    send_item(mode, first, count);
  endtask

  initial begin
    int total;
    sb = new();
    in_if.valid = 1'b0;
    in_if.mode = MODE_ALLOC;
    in_if.first_page = '0;
    in_if.page_count = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_TOTAL;
    cfg_if.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero counts, null free, full release, full-map searches
    send_item(MODE_ALLOC, 16'd0, 17'd0);
    send_item(MODE_FREE, 16'd5, 17'd0);
    send_item(MODE_RESERVE, 16'd5, 17'd0);
    send_item(MODE_RELEASE, 16'hFFFF, 17'd0);
    send_item(MODE_FREE, 16'd0, 17'd5);
    send_item(MODE_RELEASE, 16'd0, 17'd65536);
    send_item(MODE_ALLOC, 16'hFFFF, 17'd1);
    send_item(MODE_ALLOC, 16'd0, 17'd65536);
    send_item(MODE_RESERVE, 16'hFFFF, 17'd65536);
    send_item(MODE_FREE, 16'hFFFF, 17'd1);
    send_item(MODE_FREE, 16'd256, 17'd1);
    drain();
    write_cfg(REG_TOTAL, 17'h1FFFF);
    write_cfg(REG_SEARCH, 17'h0FFFF);
    send_item(MODE_ALLOC, 16'd0, 17'd1);
    send_item(MODE_ALLOC, 16'd0, 17'd1);
    drain();
    write_cfg(REG_SEARCH, 17'd0);
    send_item(MODE_ALLOC, 16'd0, 17'd65536);
    send_item(MODE_RESERVE, 16'd1, 17'd3);
    drain();
    write_cfg(REG_TOTAL, 17'd0);
    send_item(MODE_ALLOC, 16'd0, 17'd1);
    send_item(MODE_RELEASE, 16'd0, 17'd4);
    drain();
    write_cfg(REG_TOTAL, 17'd1);
    send_item(MODE_ALLOC, 16'd0, 17'd1);
    send_item(MODE_FREE, 16'd0, 17'd1);
    send_item(MODE_RESERVE, 16'd0, 17'd2);
    send_item(MODE_RELEASE, 16'd0, 17'd2);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      total = (ph == 0) ? 64 : $urandom_range(64, 512);
      write_cfg(REG_TOTAL, CNT_W'(total));
      write_cfg(REG_SEARCH, (ph == 3) ? 17'd0 : CNT_W'($urandom_range(0, total / 2)));
      idle_on = (ph != 2);
      if (ph == 1) hold_left = 400;
      for (int k = 0; k < 62; k++) random_item(total);
      drain();
    end
    idle_on = 1'b1;
    repeat (64) @(negedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bitmap_page_allocator test passed");
    end else begin
      $display("bitmap_page_allocator test failed");
    end
    $finish;
  end
endmodule

@@ bitmap_page_allocator.f @@
design/bpa_pkg.sv
design/bpa_in_if.sv
design/bpa_out_if.sv
design/bpa_cfg_if.sv
design/bpa_map_ram.sv
design/bpa_engine.sv
design/bitmap_page_allocator.sv
test/bitmap_page_allocator_tb.sv
